[sv/gfa_pkg.sv]
// ----------------------------------------------------------------------------
// gfa_pkg
// Types and constants shared by the GB2312 font address stream block.
// ----------------------------------------------------------------------------
package gfa_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ASCII_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HANZI_OFFSET = 2'd1;

    localparam logic [23:0] ASCII_BASE_RESET   = 24'h03CF80;
    localparam logic [11:0] HANZI_OFFSET_RESET = 12'd846;

    // Byte classes.
    localparam logic [7:0] CHAR_END      = 8'h00;
    localparam logic [7:0] HANZI_LEAD_LO = 8'hB0;
    localparam logic [7:0] HANZI_LEAD_HI = 8'hF7;
    localparam logic [7:0] SYM_LEAD_LO   = 8'hA1;
    localparam logic [7:0] SYM_LEAD_HI   = 8'hA3;
    localparam logic [7:0] TRAIL_LO      = 8'hA1;
    localparam logic [7:0] ASCII_LO      = 8'h20;
    localparam logic [7:0] ASCII_HI      = 8'h7E;

    // Glyphs per GB2312 row, and column steps of the two glyph sizes.
    localparam logic [6:0] ROW_SPAN    = 7'd94;
    localparam logic [7:0] NARROW_STEP = 8'd8;
    localparam logic [7:0] WIDE_STEP   = 8'd16;

    typedef struct packed {
        logic [23:0] ascii_base;
        logic [11:0] hanzi_offset;
    } t_cfg;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       string_start;
        logic [7:0] start_column;
        logic [2:0] start_page;
    } t_item;

    typedef struct packed {
        logic [23:0] glyph_address;
        logic        glyph_wide;
        logic [7:0]  glyph_column;
        logic [2:0]  glyph_page;
    } t_glyph;

    typedef struct packed {
        logic in_busy;
        logic held_valid;
        logic string_active;
    } t_core_status;

endpackage

[sv/gb2312_font_address_stream.sv]
// ----------------------------------------------------------------------------
// gb2312_font_address_stream
// Turns a GB2312/ASCII byte stream into font ROM glyph addresses and columns.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle while its result register is
// drained, and returns one glyph transfer for each printable ASCII byte and
// each complete GB2312 pair inside a string; other bytes, lead bytes and
// terminators give no transfer. A byte passes an input register and a result
// register before its glyph is offered, and the cursor and held lead byte
// are updated as the byte leaves the input register. Configuration writes
// are taken at once and must only be made while no byte is in flight.
module gb2312_font_address_stream
    import gfa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [23:0]          i_cfg_data,
    // Byte stream in.
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [23:0]          i_s_tdata,  // char_byte[7:0], start_column[15:8],
                                             // start_page[18:16], zero[23:19]
    input  logic                 i_s_tuser,  // string_start
    // Glyph stream out.
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [39:0]          o_m_tdata,  // glyph_address[23:0], glyph_column[31:24],
                                             // glyph_page[34:32], zero[39:35]
    output logic                 o_m_tuser   // glyph_wide
);

    t_cfg         cfg;
    t_item        in_item;
    t_glyph       glyph;
    t_core_status status;

    gfa_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign in_item.char_byte    = i_s_tdata[7:0];
    assign in_item.string_start = i_s_tuser;
    assign in_item.start_column = i_s_tdata[15:8];
    assign in_item.start_page   = i_s_tdata[18:16];

    gfa_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_item      (in_item),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_glyph     (glyph),
        .o_status    (status)
    );

    assign o_m_tdata = {5'd0, glyph.glyph_page, glyph.glyph_column, glyph.glyph_address};
    assign o_m_tuser = glyph.glyph_wide;

    // A stalled result with a byte already waiting blocks the input side.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready && status.in_busy) |-> !o_s_tready)
        else $error("input accepted while result stalled and input register full");

    // Wide glyphs are 32-byte aligned.
    a_wide_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[4:0] == 5'd0))
        else $error("wide glyph address not 32-byte aligned");

    // A lead byte is only held inside an active string.
    a_held_in_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.held_valid |-> status.string_active)
        else $error("lead byte held outside a string");

    // No glyph is offered right after reset.
    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

[sv/gfa_cfg_regs.sv]
// ----------------------------------------------------------------------------
// gfa_cfg_regs
// Configuration register file: ASCII glyph base and hanzi glyph offset.
// ----------------------------------------------------------------------------
module gfa_cfg_regs
    import gfa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [23:0]          i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ASCII_BASE:   n_cfg.ascii_base   = i_cfg_data;
                CFG_HANZI_OFFSET: n_cfg.hanzi_offset = i_cfg_data[11:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ascii_base   <= ASCII_BASE_RESET;
            r_cfg.hanzi_offset <= HANZI_OFFSET_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[sv/gfa_core.sv]
// ----------------------------------------------------------------------------
// gfa_core
// Input register, one-byte decode step with string state, and result register.
// ----------------------------------------------------------------------------
module gfa_core
    import gfa_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  t_item        i_item,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output t_glyph       o_glyph,
    output t_core_status o_status
);

    // Input register.
    logic  r_in_valid;
    logic  n_in_valid;
    t_item r_item;

    // String state.
    logic [7:0] r_held_lead;
    logic [7:0] n_held_lead;
    logic       r_held_valid;
    logic       n_held_valid;
    logic       r_active;
    logic       n_active;
    logic [7:0] r_column;
    logic [7:0] n_column;
    logic [2:0] r_page;
    logic [2:0] n_page;

    // Result register.
    logic   r_out_valid;
    logic   n_out_valid;
    t_glyph r_glyph;
    t_glyph n_glyph;

    logic        step;
    logic        accept;
    logic        emit;
    logic        is_hanzi_lead;
    logic        is_lead;
    logic        is_ascii;
    logic        lead_is_hanzi;
    logic [7:0]  row_off;
    logic [7:0]  col_off;
    logic [7:0]  ascii_off;
    logic [13:0] glyph_index;
    logic [23:0] wide_address;
    logic [23:0] narrow_address;

    // The held item moves on when the result register is free or being drained.
    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;
    assign accept     = i_in_valid && o_in_ready;

    assign is_hanzi_lead = (r_item.char_byte >= HANZI_LEAD_LO) &&
                           (r_item.char_byte <= HANZI_LEAD_HI);
    assign is_lead  = is_hanzi_lead ||
                      ((r_item.char_byte >= SYM_LEAD_LO) && (r_item.char_byte <= SYM_LEAD_HI));
    assign is_ascii = (r_item.char_byte >= ASCII_LO) && (r_item.char_byte <= ASCII_HI);

    // Pair address: row and column inside the GB2312 table, hanzi shifted by an offset.
    assign lead_is_hanzi = r_held_lead >= HANZI_LEAD_LO;
    assign row_off       = lead_is_hanzi ? (r_held_lead - HANZI_LEAD_LO)
                                         : (r_held_lead - SYM_LEAD_LO);
    assign col_off       = r_item.char_byte - TRAIL_LO;
    assign glyph_index   = 14'(row_off[6:0]) * 14'(ROW_SPAN) + 14'(col_off[6:0]) +
                           (lead_is_hanzi ? 14'(i_cfg.hanzi_offset) : 14'd0);
    assign wide_address  = {5'd0, glyph_index, 5'd0};

    assign ascii_off      = r_item.char_byte - ASCII_LO;
    assign narrow_address = i_cfg.ascii_base + {13'd0, ascii_off[6:0], 4'd0};

    always_comb begin
        logic       held_v;
        logic       active;
        logic [7:0] column;
        logic [2:0] page;

        held_v = r_held_valid;
        active = r_active;
        column = r_column;
        page   = r_page;

        n_held_lead  = r_held_lead;
        n_held_valid = r_held_valid;
        n_active     = r_active;
        n_column     = r_column;
        n_page       = r_page;
        emit         = 1'b0;
        n_glyph      = r_glyph;

        if (r_item.string_start) begin
            held_v = 1'b0;
            active = 1'b1;
            column = r_item.start_column;
            page   = r_item.start_page;
        end

        n_held_valid = held_v;
        n_active     = active;
        n_column     = column;
        n_page       = page;
        n_glyph.glyph_column = column;
        n_glyph.glyph_page   = page;

        if (active) begin
            if (r_item.char_byte == CHAR_END) begin
                n_held_valid = 1'b0;
                n_active     = 1'b0;
            end else if (held_v && (r_item.char_byte >= TRAIL_LO)) begin
                n_held_valid          = 1'b0;
                emit                  = 1'b1;
                n_glyph.glyph_address = wide_address;
                n_glyph.glyph_wide    = 1'b1;
                n_column              = column + WIDE_STEP;
            end else if (is_lead) begin
                // No lead is held when this branch is reached, so this byte starts a new pair.
                n_held_lead  = r_item.char_byte;
                n_held_valid = 1'b1;
            end else begin
                n_held_valid = 1'b0;
                if (is_ascii) begin
                    emit                  = 1'b1;
                    n_glyph.glyph_address = narrow_address;
                    n_glyph.glyph_wide    = 1'b0;
                    n_column              = column + NARROW_STEP;
                end
            end
        end

        if (step) begin
            n_out_valid = emit;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end

        if (accept) begin
            n_in_valid = 1'b1;
        end else if (step) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_held_lead  <= 8'd0;
            r_held_valid <= 1'b0;
            r_active     <= 1'b0;
            r_column     <= 8'd0;
            r_page       <= 3'd0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (step) begin
                r_held_lead  <= n_held_lead;
                r_held_valid <= n_held_valid;
                r_active     <= n_active;
                r_column     <= n_column;
                r_page       <= n_page;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        if (step && emit) begin
            r_glyph <= n_glyph;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_glyph     = r_glyph;

    assign o_status.in_busy       = r_in_valid;
    assign o_status.held_valid    = r_held_valid;
    assign o_status.string_active = r_active;

endmodule

[test/gb2312_font_address_stream_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb2312_font_address_stream_checker
// Watches the configuration, byte and glyph channels of the font address
// stream block, predicts every glyph from the accepted bytes and compares.
// ----------------------------------------------------------------------------
module gfa_glyph_checker
    import gfa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [23:0]          i_cfg_data,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [23:0]          i_s_tdata,
    input  logic                 i_s_tuser,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [39:0]          i_m_tdata,
    input  logic                 i_m_tuser,
    output int                   o_fail_count,
    output int                   o_glyphs_due
);

    logic [23:0] ascii_base;
    logic [11:0] hanzi_offset;

    logic [7:0]  lead_byte;
    logic        lead_held;
    logic        in_string;
    logic [7:0]  cursor_col;
    logic [2:0]  cursor_page;

    t_glyph      glyphs_due[$];
    int          mismatches = 0;

    // Places a glyph at the cursor and moves the cursor past it.
    function automatic t_glyph place_glyph(input logic [23:0] addr, input logic wide);
        t_glyph g;
        g.glyph_address = addr;
        g.glyph_wide    = wide;
        g.glyph_column  = cursor_col;
        g.glyph_page    = cursor_page;
        cursor_col      = cursor_col + (wide ? WIDE_STEP : NARROW_STEP);
        return g;
    endfunction

    // Advances the decoder by one byte; returns 1 when the byte completes a glyph.
    function automatic bit glyph_for_byte(input t_item it, output t_glyph g);
        logic [7:0]  code;
        int unsigned code_n;
        int unsigned lead_n;
        int unsigned index;
        code   = it.char_byte;
        code_n = 32'(code);
        g      = '0;
        if (it.string_start) begin
            lead_held   = 1'b0;
            lead_byte   = CHAR_END;
            in_string   = 1'b1;
            cursor_col  = it.start_column;
            cursor_page = it.start_page;
        end
        if (!in_string)
            return 1'b0;
        if (code == CHAR_END) begin
            lead_held = 1'b0;
            lead_byte = CHAR_END;
            in_string = 1'b0;
            return 1'b0;
        end
        if (lead_held) begin
            lead_n    = 32'(lead_byte);
            lead_held = 1'b0;
            lead_byte = CHAR_END;
            // Any byte from the trail range completes the pair, even a lead byte.
            if (code >= TRAIL_LO) begin
                if (lead_n >= 32'(HANZI_LEAD_LO))
                    index = (lead_n - 32'(HANZI_LEAD_LO)) * 32'(ROW_SPAN)
                          + (code_n - 32'(TRAIL_LO)) + 32'(hanzi_offset);
                else
                    index = (lead_n - 32'(SYM_LEAD_LO)) * 32'(ROW_SPAN)
                          + (code_n - 32'(TRAIL_LO));
                g = place_glyph(24'(index * 32), 1'b1);
                return 1'b1;
            end
        end
        if ((code >= HANZI_LEAD_LO && code <= HANZI_LEAD_HI) ||
            (code >= SYM_LEAD_LO && code <= SYM_LEAD_HI)) begin
            lead_byte = code;
            lead_held = 1'b1;
            return 1'b0;
        end
        if (code >= ASCII_LO && code <= ASCII_HI) begin
            g = place_glyph(24'(32'(ascii_base) + (code_n - 32'(ASCII_LO)) * 16), 1'b0);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_item  it;
        t_glyph got;
        t_glyph want;
        if (!i_rst_n) begin
            ascii_base   = ASCII_BASE_RESET;
            hanzi_offset = HANZI_OFFSET_RESET;
            lead_byte    = CHAR_END;
            lead_held    = 1'b0;
            in_string    = 1'b0;
            cursor_col   = '0;
            cursor_page  = '0;
            glyphs_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ASCII_BASE:   ascii_base   = i_cfg_data;
                    CFG_HANZI_OFFSET: hanzi_offset = i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                it.char_byte    = i_s_tdata[7:0];
                it.string_start = i_s_tuser;
                it.start_column = i_s_tdata[15:8];
                it.start_page   = i_s_tdata[18:16];
                if (glyph_for_byte(it, want))
                    glyphs_due.push_back(want);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.glyph_address = i_m_tdata[23:0];
                got.glyph_wide    = i_m_tuser;
                got.glyph_column  = i_m_tdata[31:24];
                got.glyph_page    = i_m_tdata[34:32];
                if (glyphs_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: glyph transfer with none due:", $realtime,
                                 " addr=%h wide=%b col=%0d page=%0d",
                                 got.glyph_address, got.glyph_wide,
                                 got.glyph_column, got.glyph_page);
                    mismatches++;
                end else begin
                    want = glyphs_due.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display("%0t: glyph mismatch:", $realtime,
                                     " expected addr=%h wide=%b col=%0d page=%0d,",
                                     want.glyph_address, want.glyph_wide,
                                     want.glyph_column, want.glyph_page,
                                     " got addr=%h wide=%b col=%0d page=%0d",
                                     got.glyph_address, got.glyph_wide,
                                     got.glyph_column, got.glyph_page);
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_glyphs_due <= glyphs_due.size();
    end

endmodule

[test/gb2312_font_address_stream_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb2312_font_address_stream_tb
// Drives text bytes and register writes into the font address stream block
// under random stalls on both sides; the checker predicts and compares.
// ----------------------------------------------------------------------------
module gb2312_font_address_stream_tb;
    import gfa_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASE_BYTES     = 100;
    localparam int PHASES          = 5;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_AFTER  = 40;
    localparam int HOLD_OFF_CYCLES = 250;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_ASCII_BASE;
    logic [23:0]          i_cfg_data  = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [23:0]          i_s_tdata   = '0;
    logic                 i_s_tuser   = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [39:0]          o_m_tdata;
    logic                 o_m_tuser;

    int fail_count;
    int glyphs_due;
    int cycle_count  = 0;
    int glyphs_taken = 0;
    bit sender_calm   = 1'b0;
    bit receiver_calm = 1'b0;

    always #1 i_clk = ~i_clk;

    gb2312_font_address_stream dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    gfa_glyph_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_glyphs_due (glyphs_due)
    );

    function automatic t_item text_byte(input logic [7:0] code);
        t_item it;
        it           = '0;
        it.char_byte = code;
        return it;
    endfunction

    function automatic t_item start_byte(input logic [7:0] code, input logic [7:0] col,
                                         input logic [2:0] page);
        t_item it;
        it              = '0;
        it.char_byte    = code;
        it.string_start = 1'b1;
        it.start_column = col;
        it.start_page   = page;
        return it;
    endfunction

    function automatic logic [7:0] any_lead();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(SYM_LEAD_LO, SYM_LEAD_HI));
        return 8'($urandom_range(HANZI_LEAD_LO, HANZI_LEAD_HI));
    endfunction

    // Offers one byte after a random gap and returns at the edge of its transfer.
    task automatic send_byte(input t_item it);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 39) == 0)
            sender_calm = !sender_calm;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'd0, it.start_page, it.start_column, it.char_byte};
        i_s_tuser  <= it.string_start;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Stops offering bytes and waits until the block has nothing left in flight.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (glyphs_due != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config(input logic [23:0] base, input logic [11:0] offset);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_ASCII_BASE;
        i_cfg_data  <= base;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_HANZI_OFFSET;
        i_cfg_data  <= {12'd0, offset};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // One string: mostly printable characters and complete pairs, some broken
    // pairs and noise, usually closed by a terminator.
    task automatic send_random_string(inout int sent);
        logic [7:0] text[$];
        int         tokens;
        int         pick;
        tokens = $urandom_range(0, 12);
        if ($urandom_range(0, 19) == 0)
            repeat ($urandom_range(1, 3)) send_byte(text_byte(8'($urandom_range(0, 255))));
        repeat (tokens) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                text.push_back(8'($urandom_range(ASCII_LO, ASCII_HI)));
            end else if (pick < 65) begin
                text.push_back(8'($urandom_range(HANZI_LEAD_LO, HANZI_LEAD_HI)));
                text.push_back(8'($urandom_range(TRAIL_LO, 255)));
            end else if (pick < 75) begin
                text.push_back(8'($urandom_range(SYM_LEAD_LO, SYM_LEAD_HI)));
                text.push_back(8'($urandom_range(TRAIL_LO, 255)));
            end else if (pick < 87) begin
                text.push_back(any_lead());
                text.push_back(8'($urandom_range(1, TRAIL_LO - 1)));
            end else begin
                text.push_back(8'($urandom_range(1, 255)));
            end
        end
        if (text.size() == 0 || $urandom_range(0, 9) != 0)
            text.push_back(CHAR_END);
        send_byte(start_byte(text[0], 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7))));
        for (int k = 1; k < text.size(); k++)
            send_byte(text_byte(text[k]));
        sent += text.size();
    endtask

    initial begin : glyph_sink
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            // One long hold-off lets the block fill up and push back on its input.
            if (glyphs_taken == HOLD_OFF_AFTER)
                stall = HOLD_OFF_CYCLES;
            else
                stall = receiver_calm ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 39) == 0)
                receiver_calm = !receiver_calm;
            if (stall != 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            glyphs_taken++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int sent;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed bytes under the register values after reset.
        send_byte(start_byte(8'h41, 8'd0, 3'd0));
        send_byte(text_byte(ASCII_LO));
        send_byte(text_byte(ASCII_HI));
        send_byte(text_byte(8'h1F));
        send_byte(text_byte(8'h7F));
        send_byte(text_byte(HANZI_LEAD_LO));
        send_byte(text_byte(TRAIL_LO));
        send_byte(text_byte(HANZI_LEAD_HI));
        send_byte(text_byte(8'hFF));
        send_byte(text_byte(SYM_LEAD_LO));
        send_byte(text_byte(TRAIL_LO));
        send_byte(text_byte(SYM_LEAD_HI));
        send_byte(text_byte(8'hFE));
        send_byte(text_byte(8'hB5));
        send_byte(text_byte(HANZI_LEAD_LO));
        send_byte(text_byte(8'hC0));
        send_byte(text_byte(8'hA0));
        send_byte(text_byte(8'hD1));
        send_byte(text_byte(8'h42));
        send_byte(text_byte(8'hC0));
        send_byte(text_byte(CHAR_END));
        send_byte(text_byte(8'h43));
        send_byte(start_byte(HANZI_LEAD_LO, 8'hF8, 3'd7));
        send_byte(text_byte(TRAIL_LO));
        send_byte(text_byte(8'hE0));
        send_byte(start_byte(8'h5A, 8'hFF, 3'd5));
        send_byte(start_byte(CHAR_END, 8'h55, 3'd2));
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       load_config(24'hFFFFFF, 12'hFFF);
                1:       load_config(24'h000000, 12'h000);
                3:       load_config(ASCII_BASE_RESET, HANZI_OFFSET_RESET);
                default: load_config(24'($urandom), 12'($urandom));
            endcase
            sent = 0;
            while (sent < PHASE_BYTES)
                send_random_string(sent);
            drain();
        end

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
